[hdl/plm_pkg.sv]
// Shared definitions for the positional list engine: command and status codes,
// controller states and the control bundle broadcast to the storage cells.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package plm_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // Width of the cell index carried in the control bundle (covers 256 cells).
    localparam int IDX_BITS = 8;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_GET     = 3'd2;
    localparam logic [2:0] OP_LOCATE  = 3'd3;
    localparam logic [2:0] OP_REVERSE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic                ins;
        logic                del;
        logic [IDX_BITS-1:0] idx;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/positional_list_engine_top.sv]
// Top level of the positional list engine: command decode, direction flag,
// locate scanner and result register around the plm_chain cell row.
// Depends on plm_pkg, plm_chain and plm_cell.
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY words in a chain of cells,
// one word per cell. A command transfers in when start is high and busy is
// low. Insert, delete, get and reverse complete in the accepting cycle: busy
// stays low and the result appears on the result ports, marked by done, for
// exactly one cycle starting in the cycle after the transfer. The receiver cannot
// stall, so it must capture the result in the cycle that done is high. Reverse
// never moves data; it toggles a direction flag that remaps list positions to
// cells. Locate compares the key against every cell at once, then a scanner
// walks the registered match flags one cell per cycle in list order, so a
// locate holds busy until the scan stops at the first hit or the last cell,
// and its result appears in the cycle that busy drops; on an empty list it
// behaves like the other commands. list_length always reports the length
// after the command, truncated to five bits. Words wider than 32 bits are
// compared and stored in full but read_value returns the low 32 bits.
module positional_list_engine_top #(
    parameter int CAPACITY  = plm_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = plm_pkg::WORD_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  command,
    input  wire logic [4:0]  position,
    input  wire logic [31:0] value,
    output logic             busy,
    output logic             done,
    output logic      [31:0] read_value,
    output logic      [4:0]  found_position,
    output logic      [4:0]  list_length,
    output logic      [1:0]  status
);

    // cell address, count and a compare width that holds both position and count
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 5) ? CW : 5) + 1;
    localparam int IW = plm_pkg::IDX_BITS;

    plm_pkg::state_t state_reg, state_next;

    logic                 rev_reg,    rev_next;
    logic [CW-1:0]        count_reg,  count_next;
    logic [AW-1:0]        idx_reg,    idx_next;
    logic [CW-1:0]        left_reg,   left_next;
    logic [CAPACITY-1:0]  match_reg,  match_next;
    logic                 done_reg,   done_next;
    logic [31:0]          rd_reg,     rd_next;
    logic [4:0]           found_reg,  found_next;
    logic [1:0]           status_reg, status_next;

    logic                 accept;
    logic [63:0]          value_ext;
    logic [WORD_BITS-1:0] key;
    logic [4:0]           pos_eff;
    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        cnt_w;
    logic [PW-1:0]        lidx_w;
    logic                 ins_bad;
    logic                 list_full;
    logic                 acc_bad;
    logic [PW-1:0]        ins_phys_w;
    logic [PW-1:0]        acc_phys_w;
    logic [WORD_BITS-1:0] words [CAPACITY];
    logic [CAPACITY-1:0]  match_flags;
    logic [WORD_BITS-1:0] rd_word;
    logic [63:0]          rd_ext;
    logic [CW-1:0]        cnt_m1;
    logic                 scan_hit;
    logic                 scan_last;
    logic [PW-1:0]        scan_pos_w;
    plm_pkg::cell_ctrl_t  ctrl;

    assign busy   = (state_reg != plm_pkg::S_IDLE);
    assign accept = start && !busy;

    // keep the low WORD_BITS of the incoming word
    assign value_ext = {32'd0, value};
    assign key       = value_ext[WORD_BITS-1:0];

    // position zero acts as position one
    assign pos_eff = (position == 5'd0) ? 5'd1 : position;
    assign pos_w   = PW'(pos_eff);
    assign cnt_w   = PW'(count_reg);
    assign lidx_w  = pos_w - PW'(1);

    assign ins_bad   = (pos_w > cnt_w + PW'(1));
    assign list_full = (cnt_w == PW'(CAPACITY));
    assign acc_bad   = (pos_w > cnt_w);

    // map a list position to a cell; reversed order counts from the top occupied cell
    assign ins_phys_w = rev_reg ? (cnt_w - lidx_w) : lidx_w;
    assign acc_phys_w = rev_reg ? (cnt_w - PW'(1) - lidx_w) : lidx_w;

    assign rd_word = words[acc_phys_w[AW-1:0]];
    assign rd_ext  = 64'(rd_word);

    assign ctrl.ins = accept && (command == plm_pkg::OP_INSERT) && !ins_bad && !list_full;
    assign ctrl.del = accept && (command == plm_pkg::OP_DELETE) && !acc_bad;
    assign ctrl.idx = ctrl.ins ? IW'(ins_phys_w[AW-1:0])
                               : IW'(acc_phys_w[AW-1:0]);

    plm_chain #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_chain (
        .clk         (clk),
        .ctrl        (ctrl),
        .ins_word    (key),
        .key         (key),
        .words       (words),
        .match_flags (match_flags)
    );

    // scanner: one cell per cycle, in list order
    assign cnt_m1     = count_reg - CW'(1);
    assign scan_hit   = match_reg[idx_reg];
    assign scan_last  = (left_reg == CW'(1));
    assign scan_pos_w = rev_reg ? (cnt_w - PW'(idx_reg)) : (PW'(idx_reg) + PW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plm_pkg::S_IDLE:
            begin
                if (accept && (command == plm_pkg::OP_LOCATE) && (count_reg != '0))
                begin
                    state_next = plm_pkg::S_SCAN;
                end
            end
            plm_pkg::S_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = plm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and result register
    always_comb
    begin
        rev_next    = rev_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        match_next  = match_reg;
        done_next   = 1'b0;
        rd_next     = rd_reg;
        found_next  = found_reg;
        status_next = status_reg;

        case (state_reg)
            plm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    rd_next     = '0;
                    found_next  = '0;
                    status_next = plm_pkg::ST_OK;
                    case (command)
                        plm_pkg::OP_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                status_next = plm_pkg::ST_BAD_POS;
                            end
                            else if (list_full)
                            begin
                                status_next = plm_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        plm_pkg::OP_DELETE:
                        begin
                            if (acc_bad)
                            begin
                                status_next = plm_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                rd_next    = rd_ext[31:0];
                                count_next = cnt_m1;
                            end
                        end
                        plm_pkg::OP_GET:
                        begin
                            if (acc_bad)
                            begin
                                status_next = plm_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                rd_next = rd_ext[31:0];
                            end
                        end
                        plm_pkg::OP_LOCATE:
                        begin
                            // hold the result until the scan finishes
                            if (count_reg != '0)
                            begin
                                done_next  = 1'b0;
                                match_next = match_flags;
                                left_next  = count_reg;
                                idx_next   = rev_reg ? cnt_m1[AW-1:0] : '0;
                            end
                        end
                        plm_pkg::OP_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            plm_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    done_next  = 1'b1;
                    found_next = scan_pos_w[4:0];
                end
                else if (scan_last)
                begin
                    done_next  = 1'b1;
                    found_next = '0;
                end
                else
                begin
                    // advance toward the end of the list
                    idx_next  = rev_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
                    left_next = left_reg - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plm_pkg::S_IDLE;
            rev_reg   <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rev_reg   <= rev_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        left_reg   <= left_next;
        match_reg  <= match_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign done           = done_reg;
    assign read_value     = rd_reg;
    assign found_position = found_reg;
    assign list_length    = 5'(count_reg);
    assign status         = status_reg;

    // The length never grows past the number of cells.
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(CAPACITY))
    ) else $error("list length exceeds capacity");

    // Every command other than a scanning locate yields a result next cycle.
    a_quick_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && ((command != plm_pkg::OP_LOCATE) || (count_reg == '0))) |=> done
    ) else $error("missing result after single-cycle command");

    // A result only follows a transfer or the scanner.
    a_no_spurious: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(state_reg == plm_pkg::S_SCAN))
    ) else $error("result without a command");

    // The scanner never runs on an empty list.
    a_scan_nonempty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == plm_pkg::S_SCAN) |-> ((count_reg != '0) && (left_reg != '0))
    ) else $error("scan on empty list");

endmodule

`default_nettype wire

[hdl/plm_cell.sv]
// One storage cell of the list chain: holds one word, shifts toward either
// neighbor on insert or delete, and compares its word against a search key.
// Depends on plm_pkg.
`default_nettype none

module plm_cell #(
    parameter int WORD_BITS = plm_pkg::WORD_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  wire logic                   clk,
    input  wire plm_pkg::cell_ctrl_t    ctrl,
    input  wire logic [WORD_BITS-1:0]   left_word,
    input  wire logic [WORD_BITS-1:0]   right_word,
    input  wire logic [WORD_BITS-1:0]   ins_word,
    input  wire logic [WORD_BITS-1:0]   key,
    output logic      [WORD_BITS-1:0]   word,
    output logic                        match
);

    localparam int IW = plm_pkg::IDX_BITS;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.ins)
        begin
            // take the new word at the target, shift up above it
            if (MY_IDX == ctrl.idx)
            begin
                word_next = ins_word;
            end
            else if (MY_IDX > ctrl.idx)
            begin
                word_next = left_word;
            end
        end
        else if (ctrl.del)
        begin
            // close the gap: everything from the target up moves down
            if (MY_IDX >= ctrl.idx)
            begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key);

endmodule

`default_nettype wire

[hdl/plm_chain.sv]
// Row of plm_cell instances linked to their neighbors; exposes every word
// and a per-cell match flag. Depends on plm_pkg and plm_cell.
`default_nettype none

module plm_chain #(
    parameter int CAPACITY  = plm_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = plm_pkg::WORD_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire plm_pkg::cell_ctrl_t    ctrl,
    input  wire logic [WORD_BITS-1:0]   ins_word,
    input  wire logic [WORD_BITS-1:0]   key,
    output logic      [WORD_BITS-1:0]   words [CAPACITY],
    output logic      [CAPACITY-1:0]    match_flags
);

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [WORD_BITS-1:0] left_word;
            logic [WORD_BITS-1:0] right_word;

            if (k == 0)
            begin : g_first
                assign left_word = ins_word;
            end
            else
            begin : g_inner_l
                assign left_word = words[k-1];
            end

            if (k == CAPACITY - 1)
            begin : g_last
                assign right_word = '0;
            end
            else
            begin : g_inner_r
                assign right_word = words[k+1];
            end

            plm_cell #(
                .WORD_BITS (WORD_BITS),
                .INDEX     (k)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_word  (left_word),
                .right_word (right_word),
                .ins_word   (ins_word),
                .key        (key),
                .word       (words[k]),
                .match      (match_flags[k])
            );
        end
    endgenerate

endmodule

`default_nettype wire
